// ===== design/ntc_pkg.sv =====
// Shared constants, widths and types for the non drop frame timecode unit.
`default_nettype none

package ntc_pkg;

  // Fixed-point format of the frame time and the rates
  localparam int RATE_FRACTION_BITS = 8;
  localparam int MAX_ROUNDED_RATE   = 1023;
  localparam int HALF               = (1 << RATE_FRACTION_BITS) >> 1;

  // Field widths of the channels
  localparam int FRAME_TIME_W = 40;
  localparam int RATE_W       = 20;
  localparam int HOURS_W      = 5;
  localparam int MINUTES_W    = 6;
  localparam int SECONDS_W    = 6;
  localparam int FRAMES_W     = 10;

  // Register file
  localparam int HOUR_FIELD_W  = 7;
  localparam int FRAME_FIELD_W = 10;
  localparam int PARAM_RATE_W  = 18;
  localparam int ORIGIN_W      = 32;
  localparam int DATA_W        = 32;
  localparam int ADDR_W        = 5;
  localparam int REG_IDX_W     = 3;

  localparam logic [REG_IDX_W-1:0] REG_START_HOURS      = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_START_MINUTES    = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_START_SECONDS    = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_START_FRAMES     = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_PARAM_RATE_Q8    = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_RATE_FROM_SOURCE = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_USE_START_FRAME  = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_START_FRAME      = 3'd7;

  localparam logic [HOUR_FIELD_W-1:0]  RST_START_HOURS   = 7'd1;
  localparam logic [HOUR_FIELD_W-1:0]  RST_START_MINUTES = 7'd0;
  localparam logic [HOUR_FIELD_W-1:0]  RST_START_SECONDS = 7'd0;
  localparam logic [FRAME_FIELD_W-1:0] RST_START_FRAMES  = 10'd0;
  localparam logic [PARAM_RATE_W-1:0]  RST_PARAM_RATE    = 18'd6144;
  localparam logic signed [ORIGIN_W-1:0] RST_START_FRAME = 32'sd1;
  localparam logic signed [ORIGIN_W-1:0] FIXED_ORIGIN    = 32'sd1;

  // Time constants
  localparam int DAY_SECONDS = 86400;
  localparam int UNIT_60     = 60;

  // Derived datapath widths
  localparam int R_W     = $clog2(MAX_ROUNDED_RATE + 1);
  localparam int RSUM_W  = RATE_W + 1;
  localparam int HM_W    = 13;
  localparam int HMS_W   = 19;
  localparam int PROD_W  = HMS_W + R_W;
  localparam int BASE_W  = PROD_W + 1;
  localparam int V_W     = ((FRAME_TIME_W > ORIGIN_W + RATE_FRACTION_BITS) ?
                            FRAME_TIME_W : ORIGIN_W + RATE_FRACTION_BITS) + 2;
  localparam int OFF_W   = V_W - RATE_FRACTION_BITS;
  localparam int X_W     = ((BASE_W > OFF_W) ? BASE_W : OFF_W) + 2;
  localparam int A_W     = X_W - 1;
  localparam int D_W     = 17 + R_W;
  localparam int Q1_W    = A_W - 16;
  localparam int SECS_W  = 17;
  localparam int MT_W    = 11;

  // Reciprocals for the constant divisions by 60 (exact over the value ranges)
  localparam int MIN_RECIP   = 139811;
  localparam int MIN_SHIFT   = 23;
  localparam int MIN_PROD_W  = SECS_W + 18;
  localparam int HOUR_RECIP  = 2185;
  localparam int HOUR_SHIFT  = 17;
  localparam int HOUR_PROD_W = MT_W + 12;

  // Sideband carried through the day divider
  typedef struct packed {
    logic              neg;
    logic [R_W-1:0]    r;
    logic [RATE_W-1:0] rate;
  } day_side_t;

endpackage

`default_nettype wire

// ===== design/ntc_if.sv =====
// Valid/ready channel interfaces for timecode requests and results.
`default_nettype none

interface ntc_item_if;
  import ntc_pkg::*;

  logic                           valid;
  logic                           ready;
  logic signed [FRAME_TIME_W-1:0] frame_time_q8;
  logic [RATE_W-1:0]              source_rate_q8;
  logic                           source_rate_valid;

  modport source (output valid, output frame_time_q8, output source_rate_q8,
                  output source_rate_valid, input ready);
  modport sink (input valid, input frame_time_q8, input source_rate_q8,
                input source_rate_valid, output ready);
endinterface

interface ntc_result_if;
  import ntc_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [HOURS_W-1:0]   tc_hours;
  logic [MINUTES_W-1:0] tc_minutes;
  logic [SECONDS_W-1:0] tc_seconds;
  logic [FRAMES_W-1:0]  tc_frames;
  logic [RATE_W-1:0]    reported_rate_q8;

  modport source (output valid, output tc_hours, output tc_minutes, output tc_seconds,
                  output tc_frames, output reported_rate_q8, input ready);
  modport sink (input valid, input tc_hours, input tc_minutes, input tc_seconds,
                input tc_frames, input reported_rate_q8, output ready);
endinterface

`default_nettype wire

// ===== design/ntc_div_pipe.sv =====
// Pipelined restoring divider, one quotient bit per stage, with stall chain.
`default_nettype none

module ntc_div_pipe #(
  parameter int NUM_W  = 35,
  parameter int DEN_W  = 27,
  parameter int QUO_W  = 19,
  parameter int SIDE_W = 31
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  logic [NUM_W-1:0]  req_num,
  input  logic [DEN_W-1:0]  req_den,
  input  logic [SIDE_W-1:0] req_side,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output logic [QUO_W-1:0]  rsp_quo,
  output logic [DEN_W-1:0]  rsp_rem,
  output logic [DEN_W-1:0]  rsp_den,
  output logic [SIDE_W-1:0] rsp_side
);

  // Caller keeps req_num below req_den << QUO_W and req_den nonzero.
  logic              vld    [QUO_W];
  logic              go     [QUO_W+1];
  logic [NUM_W-1:0]  rem_q  [QUO_W];
  logic [QUO_W-1:0]  quo_q  [QUO_W];
  logic [DEN_W-1:0]  den_q  [QUO_W];
  logic [SIDE_W-1:0] side_q [QUO_W];

  assign go[QUO_W] = rsp_ready;

  for (genvar k = 0; k < QUO_W; k++) begin : g_stage
    localparam int SH = QUO_W - 1 - k;
    logic              vin;
    logic [NUM_W-1:0]  rin;
    logic [QUO_W-1:0]  qin;
    logic [DEN_W-1:0]  din;
    logic [SIDE_W-1:0] sin;
    logic              fit;
    logic [NUM_W-1:0]  rnext;

    if (k == 0) begin : g_head
      assign vin = req_valid;
      assign rin = req_num;
      assign qin = '0;
      assign din = req_den;
      assign sin = req_side;
    end else begin : g_body
      assign vin = vld[k-1];
      assign rin = rem_q[k-1];
      assign qin = quo_q[k-1];
      assign din = den_q[k-1];
      assign sin = side_q[k-1];
    end

    // Move when empty or when the next stage moves
    assign go[k] = !vld[k] || go[k+1];

    // Trial subtract of the shifted divisor
    assign fit   = (rin >> SH) >= NUM_W'(din);
    assign rnext = fit ? (rin - (NUM_W'(din) << SH)) : rin;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (go[k]) begin
        vld[k] <= vin;
      end
    end

    always_ff @(posedge clk) begin
      if (go[k]) begin
        rem_q[k]  <= rnext;
        quo_q[k]  <= (qin << 1) | QUO_W'(fit);
        den_q[k]  <= din;
        side_q[k] <= sin;
      end
    end
  end

  assign req_ready = go[0];
  assign rsp_valid = vld[QUO_W-1];
  assign rsp_quo   = quo_q[QUO_W-1];
  assign rsp_rem   = rem_q[QUO_W-1][DEN_W-1:0];
  assign rsp_den   = den_q[QUO_W-1];
  assign rsp_side  = side_q[QUO_W-1];

endmodule

`default_nettype wire

// ===== design/nondrop_timecode_from_frame_unit.sv =====
// Top level of the non drop frame timecode unit: registers, pipeline and dividers.
//
// Turns a signed Q8 frame time into a non drop frame HH:MM:SS:FF timecode. Each request
// picks the source rate (when enabled and carried) or the configured rate, rounds it to
// whole frames per second R (clamped to 1..1023), weighs the start timecode as
// ((h*60+m)*60+s)*R+f, adds the frame time measured from the origin frame and rounded to
// the nearest frame (halves upward), and wraps the sum into one day of 86400*R frames.
// Throughput is one request per clock while the result side does not stall. A request
// passes four setup stages, the 19-stage day-modulo divider (one quotient bit per stage),
// one fold-back stage, the 17-stage seconds divider and three stages that split seconds
// into hours, minutes and seconds. A stalled result holds in the output register while
// empty stages upstream keep filling, so nothing is dropped or repeated. The user must
// write registers over APB only while no request is in flight, not enforced by the block.
`default_nettype none

module nondrop_timecode_from_frame_unit (
  input  logic                       clk,
  input  logic                       rst,
  ntc_item_if.sink                   item,
  ntc_result_if.source               result,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ntc_pkg::ADDR_W-1:0] paddr,
  input  logic [ntc_pkg::DATA_W-1:0] pwdata,
  output logic [ntc_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);
  import ntc_pkg::*;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [HOUR_FIELD_W-1:0]      start_hours;
  logic [HOUR_FIELD_W-1:0]      start_minutes;
  logic [HOUR_FIELD_W-1:0]      start_seconds;
  logic [FRAME_FIELD_W-1:0]     start_frames;
  logic [PARAM_RATE_W-1:0]      param_rate_q8;
  logic                         rate_from_source;
  logic                         use_start_frame;
  logic signed [ORIGIN_W-1:0]   start_frame;
  logic                         wr_en;
  logic [REG_IDX_W-1:0]         reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      start_hours      <= RST_START_HOURS;
      start_minutes    <= RST_START_MINUTES;
      start_seconds    <= RST_START_SECONDS;
      start_frames     <= RST_START_FRAMES;
      param_rate_q8    <= RST_PARAM_RATE;
      rate_from_source <= 1'b1;
      use_start_frame  <= 1'b0;
      start_frame      <= RST_START_FRAME;
    end else if (wr_en) begin
      // Drop bits above each register's width
      case (reg_idx)
        REG_START_HOURS:      start_hours      <= pwdata[HOUR_FIELD_W-1:0];
        REG_START_MINUTES:    start_minutes    <= pwdata[HOUR_FIELD_W-1:0];
        REG_START_SECONDS:    start_seconds    <= pwdata[HOUR_FIELD_W-1:0];
        REG_START_FRAMES:     start_frames     <= pwdata[FRAME_FIELD_W-1:0];
        REG_PARAM_RATE_Q8:    param_rate_q8    <= pwdata[PARAM_RATE_W-1:0];
        REG_RATE_FROM_SOURCE: rate_from_source <= pwdata[0];
        REG_USE_START_FRAME:  use_start_frame  <= pwdata[0];
        REG_START_FRAME:      start_frame      <= pwdata[ORIGIN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_START_HOURS:      prdata = DATA_W'(start_hours);
      REG_START_MINUTES:    prdata = DATA_W'(start_minutes);
      REG_START_SECONDS:    prdata = DATA_W'(start_seconds);
      REG_START_FRAMES:     prdata = DATA_W'(start_frames);
      REG_PARAM_RATE_Q8:    prdata = DATA_W'(param_rate_q8);
      REG_RATE_FROM_SOURCE: prdata = DATA_W'(rate_from_source);
      REG_USE_START_FRAME:  prdata = DATA_W'(use_start_frame);
      REG_START_FRAME:      prdata = DATA_W'(start_frame);
      default:              prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Stall chain: a stage moves when it is empty or when its successor moves.
  // ---------------------------------------------------------------------------
  logic st1_go, st2_go, st3_go, st4_go, st5_go, st6_go, st7_go, st8_go;
  logic st1_valid, st2_valid, st3_valid, st4_valid;
  logic st5_valid, st6_valid, st7_valid, st8_valid;
  logic day_req_ready, day_rsp_valid;
  logic sec_req_ready, sec_rsp_valid;

  assign st8_go = !st8_valid || result.ready;
  assign st7_go = !st7_valid || st8_go;
  assign st6_go = !st6_valid || st7_go;
  assign st5_go = !st5_valid || sec_req_ready;
  assign st4_go = !st4_valid || day_req_ready;
  assign st3_go = !st3_valid || st4_go;
  assign st2_go = !st2_valid || st3_go;
  assign st1_go = !st1_valid || st2_go;

  assign item.ready = st1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      st1_valid <= 1'b0;
      st2_valid <= 1'b0;
      st3_valid <= 1'b0;
      st4_valid <= 1'b0;
      st5_valid <= 1'b0;
      st6_valid <= 1'b0;
      st7_valid <= 1'b0;
      st8_valid <= 1'b0;
    end else begin
      if (st1_go) st1_valid <= item.valid;
      if (st2_go) st2_valid <= st1_valid;
      if (st3_go) st3_valid <= st2_valid;
      if (st4_go) st4_valid <= st3_valid;
      if (st5_go) st5_valid <= day_rsp_valid;
      if (st6_go) st6_valid <= sec_rsp_valid;
      if (st7_go) st7_valid <= st6_valid;
      if (st8_go) st8_valid <= st7_valid;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: select and round the rate, weigh hours and minutes, round the offset
  // ---------------------------------------------------------------------------
  logic [RATE_W-1:0]        rate_sel;
  logic [RSUM_W-1:0]        rate_rnd;
  logic [R_W-1:0]           rate_whole;
  logic signed [ORIGIN_W-1:0] origin;
  logic signed [V_W-1:0]    t_ext;
  logic signed [V_W-1:0]    org_ext;
  logic signed [V_W-1:0]    off_sum;

  logic [RATE_W-1:0]        st1_rate;
  logic [R_W-1:0]           st1_r;
  logic [HM_W-1:0]          st1_hm;
  logic [HOUR_FIELD_W-1:0]  st1_sec;
  logic [FRAME_FIELD_W-1:0] st1_frm;
  logic signed [OFF_W-1:0]  st1_off;

  always_comb begin
    rate_sel = (rate_from_source && item.source_rate_valid) ? item.source_rate_q8
                                                            : RATE_W'(param_rate_q8);
    rate_rnd = (RSUM_W'(rate_sel) + RSUM_W'(HALF)) >> RATE_FRACTION_BITS;
    // Zero counts at one frame per second; saturate at the top
    if (rate_rnd == '0) begin
      rate_whole = R_W'(1);
    end else if (rate_rnd > RSUM_W'(MAX_ROUNDED_RATE)) begin
      rate_whole = R_W'(MAX_ROUNDED_RATE);
    end else begin
      rate_whole = rate_rnd[R_W-1:0];
    end
    origin  = use_start_frame ? start_frame : FIXED_ORIGIN;
    t_ext   = V_W'(item.frame_time_q8);
    org_ext = V_W'(origin) <<< RATE_FRACTION_BITS;
    // Arithmetic shift of the sum below is an exact floor, so halves round upward
    off_sum = t_ext - org_ext + V_W'(HALF);
  end

  always_ff @(posedge clk) begin
    if (st1_go) begin
      st1_rate <= rate_sel;
      st1_r    <= rate_whole;
      st1_hm   <= HM_W'(start_hours) * HM_W'(UNIT_60) + HM_W'(start_minutes);
      st1_sec  <= start_seconds;
      st1_frm  <= start_frames;
      st1_off  <= off_sum[V_W-1:RATE_FRACTION_BITS];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: start time in seconds, frames in one day
  // ---------------------------------------------------------------------------
  logic [RATE_W-1:0]        st2_rate;
  logic [R_W-1:0]           st2_r;
  logic [HMS_W-1:0]         st2_hms;
  logic [D_W-1:0]           st2_d;
  logic [FRAME_FIELD_W-1:0] st2_frm;
  logic signed [OFF_W-1:0]  st2_off;

  always_ff @(posedge clk) begin
    if (st2_go) begin
      st2_rate <= st1_rate;
      st2_r    <= st1_r;
      st2_hms  <= HMS_W'(st1_hm) * HMS_W'(UNIT_60) + HMS_W'(st1_sec);
      st2_d    <= D_W'(st1_r) * D_W'(DAY_SECONDS);
      st2_frm  <= st1_frm;
      st2_off  <= st1_off;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: start seconds times the rounded rate
  // ---------------------------------------------------------------------------
  logic [RATE_W-1:0]        st3_rate;
  logic [R_W-1:0]           st3_r;
  logic [PROD_W-1:0]        st3_prod;
  logic [D_W-1:0]           st3_d;
  logic [FRAME_FIELD_W-1:0] st3_frm;
  logic signed [OFF_W-1:0]  st3_off;

  always_ff @(posedge clk) begin
    if (st3_go) begin
      st3_rate <= st2_rate;
      st3_r    <= st2_r;
      st3_prod <= PROD_W'(st2_hms) * PROD_W'(st2_r);
      st3_d    <= st2_d;
      st3_frm  <= st2_frm;
      st3_off  <= st2_off;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: total frame count; fold a negative total onto its complement so the
  // divider only sees nonnegative values (x mod d = d-1-(~x mod d) for x < 0)
  // ---------------------------------------------------------------------------
  logic signed [X_W-1:0] x_sum;
  logic                  x_neg;
  logic [A_W-1:0]        x_mag;

  logic [RATE_W-1:0]     st4_rate;
  logic [R_W-1:0]        st4_r;
  logic [D_W-1:0]        st4_d;
  logic                  st4_neg;
  logic [A_W-1:0]        st4_a;
  day_side_t             day_side_in;
  day_side_t             day_side_out;
  logic [Q1_W-1:0]       day_quo;
  logic [D_W-1:0]        day_rem;
  logic [D_W-1:0]        day_den;

  always_comb begin
    x_sum = X_W'($signed({1'b0, st3_prod})) + X_W'($signed({1'b0, st3_frm}))
          + X_W'(st3_off);
    x_neg = x_sum[X_W-1];
    x_mag = x_neg ? ~x_sum[A_W-1:0] : x_sum[A_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (st4_go) begin
      st4_rate <= st3_rate;
      st4_r    <= st3_r;
      st4_d    <= st3_d;
      st4_neg  <= x_neg;
      st4_a    <= x_mag;
    end
  end

  assign day_side_in.neg  = st4_neg;
  assign day_side_in.r    = st4_r;
  assign day_side_in.rate = st4_rate;

  // Remainder modulo one day of frames
  ntc_div_pipe #(
    .NUM_W  (A_W),
    .DEN_W  (D_W),
    .QUO_W  (Q1_W),
    .SIDE_W ($bits(day_side_t))
  ) u_day_div (
    .clk       (clk),
    .rst       (rst),
    .req_valid (st4_valid),
    .req_ready (day_req_ready),
    .req_num   (st4_a),
    .req_den   (st4_d),
    .req_side  (day_side_in),
    .rsp_valid (day_rsp_valid),
    .rsp_ready (st5_go),
    .rsp_quo   (day_quo),
    .rsp_rem   (day_rem),
    .rsp_den   (day_den),
    .rsp_side  (day_side_out)
  );

  // ---------------------------------------------------------------------------
  // Stage 5: undo the fold for negative totals
  // ---------------------------------------------------------------------------
  logic [RATE_W-1:0] st5_rate;
  logic [R_W-1:0]    st5_r;
  logic [D_W-1:0]    st5_total;
  logic [SECS_W-1:0] secs;
  logic [R_W-1:0]    frm_rem;
  logic [R_W-1:0]    sec_den;
  logic [RATE_W-1:0] sec_side;

  always_ff @(posedge clk) begin
    if (st5_go) begin
      st5_rate  <= day_side_out.rate;
      st5_r     <= day_side_out.r;
      st5_total <= day_side_out.neg ? (day_den - D_W'(1) - day_rem) : day_rem;
    end
  end

  // Seconds within the day and frame within the second
  ntc_div_pipe #(
    .NUM_W  (D_W),
    .DEN_W  (R_W),
    .QUO_W  (SECS_W),
    .SIDE_W (RATE_W)
  ) u_sec_div (
    .clk       (clk),
    .rst       (rst),
    .req_valid (st5_valid),
    .req_ready (sec_req_ready),
    .req_num   (st5_total),
    .req_den   (st5_r),
    .req_side  (st5_rate),
    .rsp_valid (sec_rsp_valid),
    .rsp_ready (st6_go),
    .rsp_quo   (secs),
    .rsp_rem   (frm_rem),
    .rsp_den   (sec_den),
    .rsp_side  (sec_side)
  );

  // ---------------------------------------------------------------------------
  // Stage 6: whole minutes in the day (reciprocal multiply for /60)
  // ---------------------------------------------------------------------------
  logic [MIN_PROD_W-1:0]  mt_prod;
  logic [RATE_W-1:0]      st6_rate;
  logic [R_W-1:0]         st6_frm;
  logic [SECS_W-1:0]      st6_secs;
  logic [MT_W-1:0]        st6_mt;

  assign mt_prod = MIN_PROD_W'(secs) * MIN_PROD_W'(MIN_RECIP);

  always_ff @(posedge clk) begin
    if (st6_go) begin
      st6_rate <= sec_side;
      // Frame remainder is below the divisor; keep it only when the divisor is sane
      st6_frm  <= (frm_rem < sec_den) ? frm_rem : '0;
      st6_secs <= secs;
      st6_mt   <= mt_prod[MIN_SHIFT +: MT_W];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 7: hours from minutes, seconds within the minute
  // ---------------------------------------------------------------------------
  logic [HOUR_PROD_W-1:0] hr_prod;
  logic [SECS_W-1:0]      sec_left;
  logic [RATE_W-1:0]      st7_rate;
  logic [R_W-1:0]         st7_frm;
  logic [MT_W-1:0]        st7_mt;
  logic [HOURS_W-1:0]     st7_hours;
  logic [SECONDS_W-1:0]   st7_sec;

  assign hr_prod  = HOUR_PROD_W'(st6_mt) * HOUR_PROD_W'(HOUR_RECIP);
  assign sec_left = st6_secs - SECS_W'(st6_mt) * SECS_W'(UNIT_60);

  always_ff @(posedge clk) begin
    if (st7_go) begin
      st7_rate  <= st6_rate;
      st7_frm   <= st6_frm;
      st7_mt    <= st6_mt;
      st7_hours <= hr_prod[HOUR_SHIFT +: HOURS_W];
      st7_sec   <= sec_left[SECONDS_W-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 8: minutes within the hour; output register, holds while stalled
  // ---------------------------------------------------------------------------
  logic [MT_W-1:0]        min_left;
  logic [HOURS_W-1:0]     st8_hours;
  logic [MINUTES_W-1:0]   st8_min;
  logic [SECONDS_W-1:0]   st8_sec;
  logic [FRAMES_W-1:0]    st8_frm;
  logic [RATE_W-1:0]      st8_rate;

  assign min_left = st7_mt - MT_W'(st7_hours) * MT_W'(UNIT_60);

  always_ff @(posedge clk) begin
    if (st8_go) begin
      st8_hours <= st7_hours;
      st8_min   <= min_left[MINUTES_W-1:0];
      st8_sec   <= st7_sec;
      st8_frm   <= FRAMES_W'(st7_frm);
      st8_rate  <= st7_rate;
    end
  end

  assign result.valid            = st8_valid;
  assign result.tc_hours         = st8_hours;
  assign result.tc_minutes       = st8_min;
  assign result.tc_seconds       = st8_sec;
  assign result.tc_frames        = st8_frm;
  assign result.reported_rate_q8 = st8_rate;

  // The day divider's quotient is not needed; only its remainder is used.
  logic day_quo_unused;
  assign day_quo_unused = ^day_quo;

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the non drop frame timecode unit.
`timescale 1ns / 1ps

module testbench;
  import ntc_pkg::*;

  localparam int CLK_HALF      = 5;
  localparam int RESET_CYCLES  = 6;
  localparam int IDLE_PERCENT  = 17;
  localparam int HOLD_CYCLES   = 200;
  localparam int TAIL_CYCLES   = 60;
  localparam int LIMIT_CYCLES  = 400000;
  localparam int MAX_REPORTS   = 100;
  localparam int SECS_PER_MIN  = 60;
  localparam int SECS_PER_HOUR = 3600;

  // One timecode as the result channel shows it
  typedef struct packed {
    logic [HOURS_W-1:0]   hours;
    logic [MINUTES_W-1:0] minutes;
    logic [SECONDS_W-1:0] seconds;
    logic [FRAMES_W-1:0]  frames;
    logic [RATE_W-1:0]    rate;
  } timecode_t;

  // One row of the directed table; typed rows carry their expected timecode
  typedef struct {
    logic signed [FRAME_TIME_W-1:0] frame_time;
    logic [RATE_W-1:0]              src_rate;
    logic                           src_valid;
    bit                             typed;
    timecode_t                      tc;
  } request_row_t;

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  ntc_item_if   item_ch ();
  ntc_result_if result_ch ();

  nondrop_timecode_from_frame_unit u_top (
    .clk     (clk),
    .rst     (rst),
    .item    (item_ch),
    .result  (result_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Shadow copy of the register file, updated when a write lands
  logic [HOUR_FIELD_W-1:0]    cfg_hours;
  logic [HOUR_FIELD_W-1:0]    cfg_minutes;
  logic [HOUR_FIELD_W-1:0]    cfg_seconds;
  logic [FRAME_FIELD_W-1:0]   cfg_frames;
  logic [PARAM_RATE_W-1:0]    cfg_param_rate;
  logic                       cfg_rate_from_source;
  logic                       cfg_use_start_frame;
  logic signed [ORIGIN_W-1:0] cfg_start_frame;

  // Timecodes owed by the block, oldest first
  timecode_t    expected_tc[$];
  request_row_t directed[$];

  int     mismatches;
  longint cycle_count;
  bit     hold_req;   // ask the result side for one long hold-off
  bit     steady;     // suppress random idling on both sides

  // Clock
  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Compute the timecode for one request from the shadow registers.
  function automatic timecode_t timecode_of(input logic signed [FRAME_TIME_W-1:0] frame_time,
                                            input logic [RATE_W-1:0] src_rate,
                                            input logic src_valid);
    timecode_t         tc;
    logic [RATE_W-1:0] rate;
    longint            whole_rate;
    longint            start_count;
    longint            origin;
    longint            offset;
    longint            day_frames;
    longint            total;
    longint            secs;
    // Source rate wins only when enabled and actually carried
    rate = (cfg_rate_from_source && src_valid) ? src_rate : RATE_W'(cfg_param_rate);
    whole_rate = (longint'(rate) + HALF) >>> RATE_FRACTION_BITS;
    if (whole_rate < 1) whole_rate = 1;
    if (whole_rate > MAX_ROUNDED_RATE) whole_rate = MAX_ROUNDED_RATE;
    // Out-of-range start fields weigh in as they stand
    start_count = ((longint'(cfg_hours) * SECS_PER_MIN + longint'(cfg_minutes)) * SECS_PER_MIN
                   + longint'(cfg_seconds)) * whole_rate + longint'(cfg_frames);
    origin = cfg_use_start_frame ? longint'(cfg_start_frame) : longint'(FIXED_ORIGIN);
    // Arithmetic shift of a signed value floors, so halves round upward
    offset = (longint'(frame_time) - (origin <<< RATE_FRACTION_BITS) + HALF)
             >>> RATE_FRACTION_BITS;
    day_frames = longint'(DAY_SECONDS) * whole_rate;
    total = (start_count + offset) % day_frames;
    if (total < 0) total += day_frames;
    secs = total / whole_rate;
    tc.hours   = HOURS_W'(secs / SECS_PER_HOUR);
    tc.minutes = MINUTES_W'((secs / SECS_PER_MIN) % SECS_PER_MIN);
    tc.seconds = SECONDS_W'(secs % SECS_PER_MIN);
    tc.frames  = FRAMES_W'(total % whole_rate);
    tc.rate    = rate;
    return tc;
  endfunction

  // Pick a frame time: wide random, near the origin, on rounding halves, whole days away or signed 32-bit.
  function automatic logic signed [FRAME_TIME_W-1:0] pick_frame_time();
    longint      origin_q8;
    longint      days;
    logic [63:0] raw;
    origin_q8 = (cfg_use_start_frame ? longint'(cfg_start_frame) : longint'(FIXED_ORIGIN))
                <<< RATE_FRACTION_BITS;
    raw = {$urandom, $urandom};
    case ($urandom_range(4))
      0: return raw[FRAME_TIME_W-1:0];
      1: return FRAME_TIME_W'(origin_q8 + longint'($signed(raw[19:0])));
      2: return FRAME_TIME_W'(origin_q8 + (longint'($signed(raw[47:32])) <<< RATE_FRACTION_BITS)
                              + HALF - 1 + longint'($urandom_range(2)));
      3: begin
        days = longint'($urandom_range(6)) - 3;
        return FRAME_TIME_W'(origin_q8 + days * DAY_SECONDS * longint'($urandom_range(1, 64))
                             * (longint'(1) <<< RATE_FRACTION_BITS)
                             + longint'($signed(raw[11:0])));
      end
      default: return FRAME_TIME_W'(longint'($signed(raw[31:0])));
    endcase
  endfunction

  // Pick a source rate: wide random, broadcast rates, tiny rates, or around the clamp.
  function automatic logic [RATE_W-1:0] pick_source_rate();
    case ($urandom_range(3))
      0: return RATE_W'($urandom);
      1: begin
        case ($urandom_range(5))
          0:       return RATE_W'(6138);
          1:       return RATE_W'(6144);
          2:       return RATE_W'(6400);
          3:       return RATE_W'(7672);
          4:       return RATE_W'(7680);
          default: return RATE_W'(15360);
        endcase
      end
      2: return RATE_W'($urandom_range(600));
      default: return RATE_W'($urandom_range(261500, 262400));
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatches < MAX_REPORTS) $display("MISMATCH at %0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input longint got, input longint want);
    if (got != want) report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
  endtask

  task automatic add_row(input logic signed [FRAME_TIME_W-1:0] frame_time,
                         input logic [RATE_W-1:0] src_rate, input logic src_valid,
                         input bit typed = 1'b0, input int hours = 0, input int minutes = 0,
                         input int seconds = 0, input int frames = 0, input int rate = 0);
    request_row_t row;
    row.frame_time = frame_time;
    row.src_rate   = src_rate;
    row.src_valid  = src_valid;
    row.typed      = typed;
    row.tc         = '{HOURS_W'(hours), MINUTES_W'(minutes), SECONDS_W'(seconds),
                       FRAMES_W'(frames), RATE_W'(rate)};
    directed.insert(directed.size(), row);
  endtask

  // Offer one request, starting and ending at a falling edge. Idle first at random,
  // then hold the request until the block takes it and log the owed timecode.
  task automatic send_request(input logic signed [FRAME_TIME_W-1:0] frame_time,
                              input logic [RATE_W-1:0] src_rate, input logic src_valid,
                              input bit typed, input timecode_t typed_tc);
    while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
      item_ch.valid <= 1'b0;
      @(negedge clk);
    end
    item_ch.valid             <= 1'b1;
    item_ch.frame_time_q8     <= frame_time;
    item_ch.source_rate_q8    <= src_rate;
    item_ch.source_rate_valid <= src_valid;
    do @(posedge clk); while (!item_ch.ready);
    expected_tc.insert(expected_tc.size(),
                       typed ? typed_tc : timecode_of(frame_time, src_rate, src_valid));
    @(negedge clk);
  endtask

  // APB write: setup cycle, access cycle, register lands when pready is seen.
  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'({idx, 2'b00});
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    // Drop the bits above each register's width, as the block does
    case (idx)
      REG_START_HOURS:      cfg_hours            = value[HOUR_FIELD_W-1:0];
      REG_START_MINUTES:    cfg_minutes          = value[HOUR_FIELD_W-1:0];
      REG_START_SECONDS:    cfg_seconds          = value[HOUR_FIELD_W-1:0];
      REG_START_FRAMES:     cfg_frames           = value[FRAME_FIELD_W-1:0];
      REG_PARAM_RATE_Q8:    cfg_param_rate       = value[PARAM_RATE_W-1:0];
      REG_RATE_FROM_SOURCE: cfg_rate_from_source = value[0];
      REG_USE_START_FRAME:  cfg_use_start_frame  = value[0];
      REG_START_FRAME:      cfg_start_frame      = value[ORIGIN_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic configure(input logic [DATA_W-1:0] hours, input logic [DATA_W-1:0] minutes,
                           input logic [DATA_W-1:0] seconds, input logic [DATA_W-1:0] frames,
                           input logic [DATA_W-1:0] param_rate,
                           input logic [DATA_W-1:0] rate_from_source,
                           input logic [DATA_W-1:0] use_start_frame,
                           input logic [DATA_W-1:0] start_frame);
    write_reg(REG_START_HOURS, hours);
    write_reg(REG_START_MINUTES, minutes);
    write_reg(REG_START_SECONDS, seconds);
    write_reg(REG_START_FRAMES, frames);
    write_reg(REG_PARAM_RATE_Q8, param_rate);
    write_reg(REG_RATE_FROM_SOURCE, rate_from_source);
    write_reg(REG_USE_START_FRAME, use_start_frame);
    write_reg(REG_START_FRAME, start_frame);
  endtask

  // Hold the request side until every owed timecode is back, then idle for the extra count given.
  task automatic wait_for_results(input int extra);
    while (expected_tc.size() != 0) @(negedge clk);
    repeat (extra) @(negedge clk);
  endtask

  // Random requests; optionally run a window with no idling and trigger the long hold-off.
  task automatic run_random(input int count, input int steady_from = -1,
                            input int steady_to = -1, input int hold_at = -1);
    for (int i = 0; i < count; i++) begin
      steady = (i >= steady_from && i < steady_to);
      if (i == hold_at) hold_req = 1'b1;
      send_request(pick_frame_time(), pick_source_rate(), $urandom_range(99) < 70, 1'b0, '0);
    end
    steady = 1'b0;
    item_ch.valid <= 1'b0;
  endtask

  // Result side: drop ready at random, or for one long counted stretch on request.
  initial begin : result_sink
    int hold_left;
    hold_left = 0;
    result_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_ch.ready <= 1'b0;
      end else if (steady) begin
        result_ch.ready <= 1'b1;
      end else begin
        result_ch.ready <= ($urandom_range(99) >= IDLE_PERCENT);
      end
    end
  end

  // Compare every taken result with the oldest owed timecode.
  always @(posedge clk) begin
    timecode_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (expected_tc.size() == 0) begin
        report_mismatch("result with no request outstanding");
      end else begin
        want = expected_tc.pop_front();
        check_field("tc_hours", result_ch.tc_hours, want.hours);
        check_field("tc_minutes", result_ch.tc_minutes, want.minutes);
        check_field("tc_seconds", result_ch.tc_seconds, want.seconds);
        check_field("tc_frames", result_ch.tc_frames, want.frames);
        check_field("reported_rate_q8", result_ch.reported_rate_q8, want.rate);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("nondrop_timecode_from_frame_unit test failed");
      $finish;
    end
  end

  initial begin : stimulus
    rst                       = 1'b1;
    psel                      = 1'b0;
    penable                   = 1'b0;
    pwrite                    = 1'b0;
    paddr                     = '0;
    pwdata                    = '0;
    item_ch.valid             = 1'b0;
    item_ch.frame_time_q8     = '0;
    item_ch.source_rate_q8    = '0;
    item_ch.source_rate_valid = 1'b0;
    cfg_hours                 = RST_START_HOURS;
    cfg_minutes               = RST_START_MINUTES;
    cfg_seconds               = RST_START_SECONDS;
    cfg_frames                = RST_START_FRAMES;
    cfg_param_rate            = RST_PARAM_RATE;
    cfg_rate_from_source      = 1'b1;
    cfg_use_start_frame       = 1'b0;
    cfg_start_frame           = RST_START_FRAME;

    // Directed table, reset registers: 01:00:00:00 start, 24 fps, origin at frame 1.
    // Frame 1 itself, and the rounding halves on both sides of it.
    add_row(256, 0, 0, 1, 1, 0, 0, 0, 6144);
    add_row(0, 0, 0, 1, 0, 59, 59, 23, 6144);
    add_row(384, 0, 0, 1, 1, 0, 0, 1, 6144);
    add_row(383, 0, 0, 1, 1, 0, 0, 0, 6144);
    add_row(128, 0, 0, 1, 1, 0, 0, 0, 6144);
    add_row(127, 0, 0, 1, 0, 59, 59, 23, 6144);
    // Negative times: halves still round upward
    add_row(-128, 0, 0, 1, 0, 59, 59, 23, 6144);
    add_row(-129, 0, 0, 1, 0, 59, 59, 22, 6144);
    // Zero source rate counts at one frame per second; the widest saturates at 1023
    add_row(256, 0, 1, 1, 1, 0, 0, 0, 0);
    add_row(256, 'hFFFFF, 1, 1, 1, 0, 0, 0, 'hFFFFF);
    // Rate rounding edges around one frame per second
    add_row(0, 127, 1, 1, 0, 59, 59, 0, 127);
    add_row(0, 128, 1, 1, 0, 59, 59, 0, 128);
    add_row(0, 383, 1);
    add_row(0, 384, 1);
    // Carried rate that is not flagged valid falls back to the register
    add_row(256, 'h12345, 0, 1, 1, 0, 0, 0, 6144);
    // Exactly one day ahead and one day behind wrap back to the start
    add_row(530841856, 0, 0, 1, 1, 0, 0, 0, 6144);
    add_row(-530841344, 0, 0, 1, 1, 0, 0, 0, 6144);
    // Frame time extremes
    add_row(40'sh7F_FFFF_FFFF, 'h55555, 1);
    add_row(40'sh80_0000_0000, 'hAAAAA, 1);
    // 30 fps source, 1h1m1s past the origin
    add_row(28116736, 7680, 1, 1, 2, 1, 1, 0, 7680);
    // Saturation edge of the rounded rate
    add_row(0, 261888, 1);
    add_row(0, 261759, 1);
    add_row(0, 261760, 1);
    // Last frame of the day
    add_row(508723200, 0, 0, 1, 23, 59, 59, 23, 6144);

    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;
    repeat (2) @(negedge clk);

    foreach (directed[i])
      send_request(directed[i].frame_time, directed[i].src_rate, directed[i].src_valid,
                   directed[i].typed, directed[i].tc);
    item_ch.valid <= 1'b0;
    wait_for_results(4);

    // Reset registers: a stretch with no idling, then the long result hold-off
    run_random(220, 40, 160, 180);
    wait_for_results(4);

    // Last frame of the day as start, 30 fps from the register only, lowest origin
    configure(23, 59, 59, 29, 7680, 0, 1, 32'h8000_0000);
    run_random(200);
    wait_for_results(4);

    // All start fields and the rate at their widest, garbage above each width,
    // highest origin
    configure(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
              32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
    run_random(200);
    wait_for_results(4);

    // Everything zero: register rate 0 counts at one frame per second
    configure(0, 0, 0, 0, 0, 0, 0, 0);
    run_random(150);
    wait_for_results(4);

    // Register rate of 1000 frames per second, source enabled, origin before zero
    configure(10, 20, 30, 5, 256000, 1, 1, -1000);
    run_random(150);
    wait_for_results(4);

    // Random settings: first in range, then raw words
    configure($urandom_range(23), $urandom_range(59), $urandom_range(59), $urandom_range(29),
              $urandom_range(256, 256000), 1, $urandom_range(1), $urandom);
    run_random(110);
    wait_for_results(4);
    repeat (2) begin
      configure($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      run_random(110);
      wait_for_results(4);
    end

    // Drain and give a late or extra result time to show up
    wait_for_results(TAIL_CYCLES);
    if (mismatches == 0) begin
      $display("nondrop_timecode_from_frame_unit test passed");
    end else begin
      $display("nondrop_timecode_from_frame_unit test failed");
    end
    $finish;
  end

endmodule
